// File: hw/rtl/rcr_pkg.sv
// Shared types and constants of the raised-cosine ramp core.
`default_nettype none
package rcr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ANG_FRAC  = 30;
  localparam int SPAN_W    = 40;
  localparam int REM_W     = SPAN_W + 1;
  localparam int T_W       = ANG_FRAC + 1;
  localparam int ANG_W     = 31;
  localparam int X2_W      = 32;
  localparam int TERM_W    = 33;
  localparam int SER_W     = TERM_W + 1;
  localparam int DF_W      = FRAC_BITS + 1;
  localparam int GRAD_W    = 48;
  localparam int GRAD_SH   = 2 * FRAC_BITS - ANG_FRAC;
  localparam int BB_W      = 31;
  localparam int DI_W      = BB_W + GRAD_SH;
  localparam int MAG_W     = DI_W + 32 - FRAC_BITS;
  localparam int TERMS     = 7;
  localparam int LATENCY   = 2 + ANG_FRAC + 2 + 3 * TERMS + 1 + DI_W + 3;

  localparam logic [31:0]     PI_Q30  = 32'd3373259426;
  localparam logic [DF_W-1:0] DF_ONE  = DF_W'(64'd1 << FRAC_BITS);
  localparam logic [DF_W-1:0] DF_HALF = DF_W'(64'd1 << (FRAC_BITS - 1));

  typedef struct packed {
    logic [31:0] intensity;
    logic [31:0] min_intensity;
    logic [31:0] max_intensity;
    logic [23:0] max_scale;
    logic        want_gradients;
  } req_t;

  typedef struct packed {
    logic        [DF_W-1:0]   damage_factor;
    logic signed [GRAD_W-1:0] grad_intensity;
    logic signed [GRAD_W-1:0] grad_min_bound;
    logic signed [GRAD_W-1:0] grad_max_bound;
    logic signed [GRAD_W-1:0] grad_scale;
    logic                     span_degenerate;
  } rsp_t;

  typedef struct packed {
    logic [SPAN_W-1:0] span;
    logic [31:0]       max_intensity;
    logic [23:0]       max_scale;
    logic [T_W-1:0]    t30;
    logic [DF_W-1:0]   damage;
    logic              want;
    logic              ramp;
    logic              degen;
    logic              upper;
  } ctx_t;

endpackage
`default_nettype wire

// File: hw/rtl/rcr_div_cell.sv
// One restoring-division step: shifts in a numerator bit and emits one quotient bit.
`default_nettype none
module rcr_div_cell #(
  parameter int QUO_W = 31,
  parameter int NUM_W = 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  input  wire rcr_pkg::ctx_t              ctx_i,
  input  wire logic [rcr_pkg::REM_W-1:0]  rem_i,
  input  wire logic [QUO_W-1:0]           quo_i,
  input  wire logic [NUM_W-1:0]           num_i,
  output logic                            valid_o,
  output rcr_pkg::ctx_t                   ctx_o,
  output logic [rcr_pkg::REM_W-1:0]       rem_o,
  output logic [QUO_W-1:0]                quo_o,
  output logic [NUM_W-1:0]                num_o
);
  import rcr_pkg::*;

  logic [REM_W-1:0] shifted;
  logic [REM_W-1:0] den;
  logic             ge;

  assign shifted = {rem_i[REM_W-2:0], num_i[NUM_W-1]};
  assign den     = REM_W'(ctx_i.span);
  assign ge      = shifted >= den;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctx_o <= ctx_i;
    rem_o <= ge ? shifted - den : shifted;
    quo_o <= {quo_i[QUO_W-2:0], ge};
    num_o <= num_i << 1;
  end

endmodule
`default_nettype wire

// File: hw/rtl/rcr_term_cell.sv
// One sine/cosine series term: multiply by x^2, divide by a constant, accumulate.
`default_nettype none
module rcr_term_cell #(
  parameter int unsigned DIV_S = 6,
  parameter int unsigned DIV_C = 2,
  parameter bit          SUB   = 1'b1
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               valid_i,
  input  wire rcr_pkg::ctx_t                      ctx_i,
  input  wire logic        [rcr_pkg::X2_W-1:0]    x2_i,
  input  wire logic        [rcr_pkg::TERM_W-1:0]  ts_i,
  input  wire logic        [rcr_pkg::TERM_W-1:0]  tc_i,
  input  wire logic signed [rcr_pkg::SER_W-1:0]   ss_i,
  input  wire logic signed [rcr_pkg::SER_W-1:0]   cc_i,
  output logic                                    valid_o,
  output rcr_pkg::ctx_t                           ctx_o,
  output logic             [rcr_pkg::X2_W-1:0]    x2_o,
  output logic             [rcr_pkg::TERM_W-1:0]  ts_o,
  output logic             [rcr_pkg::TERM_W-1:0]  tc_o,
  output logic signed      [rcr_pkg::SER_W-1:0]   ss_o,
  output logic signed      [rcr_pkg::SER_W-1:0]   cc_o
);
  import rcr_pkg::*;

  localparam longint unsigned RECIP_SL = (64'd1 << TERM_W) / DIV_S;
  localparam longint unsigned RECIP_CL = (64'd1 << TERM_W) / DIV_C;
  localparam logic [TERM_W:0] RECIP_S  = RECIP_SL[TERM_W:0];
  localparam logic [TERM_W:0] RECIP_C  = RECIP_CL[TERM_W:0];
  localparam logic [7:0]      DS       = 8'(DIV_S);
  localparam logic [7:0]      DC       = 8'(DIV_C);

  logic                     v1_q, v2_q;
  ctx_t                     ctx1_q, ctx2_q;
  logic [X2_W-1:0]          x21_q, x22_q;
  logic [TERM_W-1:0]        ps1_q, pc1_q, ps2_q, pc2_q, qs2_q, qc2_q;
  logic signed [SER_W-1:0]  ss1_q, cc1_q, ss2_q, cc2_q;

  logic [TERM_W+X2_W-1:0]   mul_s, mul_c;
  logic [2*TERM_W:0]        rec_s, rec_c;
  logic [TERM_W+7:0]        bk_s, bk_c;
  logic [TERM_W-1:0]        rs, rc, qs, qc;

  assign mul_s = ts_i * x2_i;
  assign mul_c = tc_i * x2_i;
  assign rec_s = ps1_q * RECIP_S;
  assign rec_c = pc1_q * RECIP_C;
  assign bk_s  = qs2_q * DS;
  assign bk_c  = qc2_q * DC;
  assign rs    = ps2_q - bk_s[TERM_W-1:0];
  assign rc    = pc2_q - bk_c[TERM_W-1:0];
  assign qs    = qs2_q + TERM_W'(rs >= TERM_W'(DS));
  assign qc    = qc2_q + TERM_W'(rc >= TERM_W'(DC));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      v1_q    <= valid_i;
      v2_q    <= v1_q;
      valid_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ctx1_q <= ctx_i;
    x21_q  <= x2_i;
    ps1_q  <= mul_s[ANG_FRAC +: TERM_W];
    pc1_q  <= mul_c[ANG_FRAC +: TERM_W];
    ss1_q  <= ss_i;
    cc1_q  <= cc_i;

    ctx2_q <= ctx1_q;
    x22_q  <= x21_q;
    ps2_q  <= ps1_q;
    pc2_q  <= pc1_q;
    qs2_q  <= rec_s[TERM_W +: TERM_W];
    qc2_q  <= rec_c[TERM_W +: TERM_W];
    ss2_q  <= ss1_q;
    cc2_q  <= cc1_q;

    ctx_o  <= ctx2_q;
    x2_o   <= x22_q;
    ts_o   <= qs;
    tc_o   <= qc;
    if (SUB) begin
      ss_o <= ss2_q - $signed({1'b0, qs});
      cc_o <= cc2_q - $signed({1'b0, qc});
    end else begin
      ss_o <= ss2_q + $signed({1'b0, qs});
      cc_o <= cc2_q + $signed({1'b0, qc});
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/raised_cosine_ramp_with_gradients_core.sv
// Top level of the raised-cosine damage ramp with partial derivatives.
//
// Usage: drive req_i and raise start_i; a transaction is taken at each rising
// edge with start_i high and busy_o low. busy_o stays low, so a new
// transaction may be offered in every cycle.
// Each transaction produces exactly one result on result_o, marked by done_o
// for one cycle, in order.
// The pipeline chain is one upper-bound multiply stage, one region
// decode stage, 30 cells of the position ratio divider, angle and x^2 stages,
// seven 3-stage series term cells, one damage stage, 33 cells of the gradient
// divider, two gradient multiply stages and the output register.
// Throughput is one transaction per cycle.
// Reset clears all valid bits; transactions in flight are dropped and no
// done_o follows.
// The receiver cannot stall: each result is shown for one cycle only.
`default_nettype none
module raised_cosine_ramp_with_gradients_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire rcr_pkg::req_t req_i,
  output logic               busy_o,
  output logic               done_o,
  output rcr_pkg::rsp_t      result_o
);
  import rcr_pkg::*;

  localparam logic signed [SER_W-1:0] ONE_S   = SER_W'(64'd1 << ANG_FRAC);
  localparam logic [T_W-1:0]          ONE_T   = T_W'(64'd1 << ANG_FRAC);
  localparam logic [T_W-1:0]          HALF_T  = T_W'(64'd1 << (ANG_FRAC - 1));
  localparam logic [MAG_W-1:0]        NEG_LIM = MAG_W'(64'd1 << (GRAD_W - 1));

  function automatic logic [GRAD_W-1:0] neg_sat(input logic [MAG_W-1:0] mag);
    logic [MAG_W-1:0] lim;
    logic [MAG_W-1:0] neg;
    lim = (mag > NEG_LIM) ? NEG_LIM : mag;
    neg = '0 - lim;
    return neg[GRAD_W-1:0];
  endfunction

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // upper bound
  logic              s1_vld_q;
  req_t              s1_req_q;
  logic [SPAN_W-1:0] s1_hi_q;
  logic [55:0]       hi_prod;
  assign hi_prod = req_i.max_intensity * req_i.max_scale;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_req_q <= req_i;
    s1_hi_q  <= hi_prod[FRAC_BITS +: SPAN_W];
  end

  // region decode and ratio divider
  logic              rdv_vld [0:ANG_FRAC];
  ctx_t              rdv_ctx [0:ANG_FRAC];
  logic [REM_W-1:0]  rdv_rem [0:ANG_FRAC];
  logic [T_W-1:0]    rdv_quo [0:ANG_FRAC];
  logic [0:0]        rdv_num [0:ANG_FRAC];

  ctx_t              s2_ctx;
  logic [REM_W-1:0]  s2_rem;
  logic [T_W-1:0]    s2_quo;

  always_comb begin
    logic              below, above, degen, q0;
    logic [SPAN_W-1:0] span;
    logic [31:0]       num;
    below = s1_req_q.intensity < s1_req_q.min_intensity;
    above = SPAN_W'(s1_req_q.intensity) > s1_hi_q;
    degen = s1_hi_q <= SPAN_W'(s1_req_q.min_intensity);
    span  = s1_hi_q - SPAN_W'(s1_req_q.min_intensity);
    num   = s1_req_q.intensity - s1_req_q.min_intensity;
    q0    = SPAN_W'(num) == span;
    s2_ctx.span          = span;
    s2_ctx.max_intensity = s1_req_q.max_intensity;
    s2_ctx.max_scale     = s1_req_q.max_scale;
    s2_ctx.t30           = '0;
    s2_ctx.damage        = below ? '0 : (above ? DF_ONE : DF_HALF);
    s2_ctx.want          = s1_req_q.want_gradients;
    s2_ctx.ramp          = !below && !above && !degen;
    s2_ctx.degen         = degen;
    s2_ctx.upper         = 1'b0;
    s2_rem = q0 ? '0 : REM_W'(num);
    s2_quo = T_W'(q0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdv_vld[0] <= 1'b0;
    end else begin
      rdv_vld[0] <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rdv_ctx[0] <= s2_ctx;
    rdv_rem[0] <= s2_rem;
    rdv_quo[0] <= s2_quo;
    rdv_num[0] <= 1'b0;
  end

  for (genvar i = 0; i < ANG_FRAC; i++) begin : g_rdiv
    rcr_div_cell #(
      .QUO_W(T_W),
      .NUM_W(1)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(rdv_vld[i]),
      .ctx_i  (rdv_ctx[i]),
      .rem_i  (rdv_rem[i]),
      .quo_i  (rdv_quo[i]),
      .num_i  (rdv_num[i]),
      .valid_o(rdv_vld[i+1]),
      .ctx_o  (rdv_ctx[i+1]),
      .rem_o  (rdv_rem[i+1]),
      .quo_o  (rdv_quo[i+1]),
      .num_o  (rdv_num[i+1])
    );
  end

  // angle on the quarter wave
  logic             a_vld_q;
  ctx_t             a_ctx_q;
  ctx_t             a_ctx_d;
  logic [ANG_W-1:0] a_ang_q;
  logic [T_W-1:0]   t30, tq;
  logic             upper;
  logic [T_W+31:0]  ang_prod;

  assign t30      = rdv_quo[ANG_FRAC];
  assign upper    = t30 > HALF_T;
  assign tq       = upper ? ONE_T - t30 : t30;
  assign ang_prod = tq * PI_Q30 + (T_W+32)'(HALF_T);

  always_comb begin
    a_ctx_d       = rdv_ctx[ANG_FRAC];
    a_ctx_d.t30   = t30;
    a_ctx_d.upper = upper;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= rdv_vld[ANG_FRAC];
    end
  end

  always_ff @(posedge clk_i) begin
    a_ctx_q <= a_ctx_d;
    a_ang_q <= ang_prod[ANG_FRAC +: ANG_W];
  end

  // series chain
  logic                    tm_vld [0:TERMS];
  ctx_t                    tm_ctx [0:TERMS];
  logic [X2_W-1:0]         tm_x2  [0:TERMS];
  logic [TERM_W-1:0]       tm_ts  [0:TERMS];
  logic [TERM_W-1:0]       tm_tc  [0:TERMS];
  logic signed [SER_W-1:0] tm_ss  [0:TERMS];
  logic signed [SER_W-1:0] tm_cc  [0:TERMS];
  logic [2*ANG_W-1:0]      sq_prod;

  assign sq_prod = a_ang_q * a_ang_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tm_vld[0] <= 1'b0;
    end else begin
      tm_vld[0] <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tm_ctx[0] <= a_ctx_q;
    tm_x2[0]  <= sq_prod[ANG_FRAC +: X2_W];
    tm_ts[0]  <= TERM_W'(a_ang_q);
    tm_tc[0]  <= TERM_W'(ONE_T);
    tm_ss[0]  <= SER_W'(a_ang_q);
    tm_cc[0]  <= ONE_S;
  end

  for (genvar k = 0; k < TERMS; k++) begin : g_term
    rcr_term_cell #(
      .DIV_S((2 * (k + 1)) * (2 * (k + 1) + 1)),
      .DIV_C((2 * (k + 1) - 1) * (2 * (k + 1))),
      .SUB  ((k % 2) == 0)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(tm_vld[k]),
      .ctx_i  (tm_ctx[k]),
      .x2_i   (tm_x2[k]),
      .ts_i   (tm_ts[k]),
      .tc_i   (tm_tc[k]),
      .ss_i   (tm_ss[k]),
      .cc_i   (tm_cc[k]),
      .valid_o(tm_vld[k+1]),
      .ctx_o  (tm_ctx[k+1]),
      .x2_o   (tm_x2[k+1]),
      .ts_o   (tm_ts[k+1]),
      .tc_o   (tm_tc[k+1]),
      .ss_o   (tm_ss[k+1]),
      .cc_o   (tm_cc[k+1])
    );
  end

  // damage and gradient numerator
  logic              dv_vld [0:DI_W];
  ctx_t              dv_ctx [0:DI_W];
  logic [REM_W-1:0]  dv_rem [0:DI_W];
  logic [DI_W-1:0]   dv_quo [0:DI_W];
  logic [DI_W-1:0]   dv_num [0:DI_W];

  ctx_t              p_ctx;
  logic [DI_W-1:0]   p_num;

  always_comb begin
    logic signed [SER_W-1:0] cv, sv, twice_s;
    logic [X2_W-1:0]         rnd;
    logic [DF_W-1:0]         df;
    logic [T_W+31:0]         bb_prod;
    cv = tm_ctx[TERMS].upper ? -tm_cc[TERMS] : tm_cc[TERMS];
    if (cv > ONE_S) begin
      cv = ONE_S;
    end else if (cv < -ONE_S) begin
      cv = -ONE_S;
    end
    sv = tm_ss[TERMS];
    if (sv < 0) begin
      sv = '0;
    end else if (sv > ONE_S) begin
      sv = ONE_S;
    end
    twice_s = ONE_S - cv;
    rnd     = twice_s[X2_W-1:0] + X2_W'(64'd1 << (ANG_FRAC - FRAC_BITS));
    df      = rnd[ANG_FRAC + 1 - FRAC_BITS +: DF_W];
    if (df > DF_ONE) begin
      df = DF_ONE;
    end
    bb_prod = sv[T_W-1:0] * PI_Q30;
    p_ctx   = tm_ctx[TERMS];
    if (tm_ctx[TERMS].ramp) begin
      p_ctx.damage = df;
    end
    p_num = DI_W'(bb_prod[ANG_FRAC + 1 +: BB_W]) << GRAD_SH;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld[0] <= 1'b0;
    end else begin
      dv_vld[0] <= tm_vld[TERMS];
    end
  end

  always_ff @(posedge clk_i) begin
    dv_ctx[0] <= p_ctx;
    dv_rem[0] <= '0;
    dv_quo[0] <= '0;
    dv_num[0] <= p_num;
  end

  for (genvar j = 0; j < DI_W; j++) begin : g_gdiv
    rcr_div_cell #(
      .QUO_W(DI_W),
      .NUM_W(DI_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(dv_vld[j]),
      .ctx_i  (dv_ctx[j]),
      .rem_i  (dv_rem[j]),
      .quo_i  (dv_quo[j]),
      .num_i  (dv_num[j]),
      .valid_o(dv_vld[j+1]),
      .ctx_o  (dv_ctx[j+1]),
      .rem_o  (dv_rem[j+1]),
      .quo_o  (dv_quo[j+1]),
      .num_o  (dv_num[j+1])
    );
  end

  // gradient products
  logic                  g1_vld_q, g2_vld_q;
  ctx_t                  g1_ctx_q, g2_ctx_q;
  logic [DI_W-1:0]       g1_di_q, g1_pm_q, g1_xt_q, g2_di_q, g2_pm_q;
  logic [MAG_W-1:0]      g2_p3_q, g2_p4_q;
  logic [DI_W-1:0]       di;
  logic [T_W-1:0]        omt;
  logic [DI_W+T_W-1:0]   pm_prod, xt_prod;
  logic [DI_W+23:0]      p3_prod;
  logic [DI_W+31:0]      p4_prod;

  assign di      = dv_quo[DI_W];
  assign omt     = ONE_T - dv_ctx[DI_W].t30;
  assign pm_prod = di * omt;
  assign xt_prod = di * dv_ctx[DI_W].t30;
  assign p3_prod = g1_xt_q * g1_ctx_q.max_scale;
  assign p4_prod = g1_xt_q * g1_ctx_q.max_intensity;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g1_vld_q <= 1'b0;
      g2_vld_q <= 1'b0;
    end else begin
      g1_vld_q <= dv_vld[DI_W];
      g2_vld_q <= g1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    g1_ctx_q <= dv_ctx[DI_W];
    g1_di_q  <= di;
    g1_pm_q  <= pm_prod[ANG_FRAC +: DI_W];
    g1_xt_q  <= xt_prod[ANG_FRAC +: DI_W];
    g2_ctx_q <= g1_ctx_q;
    g2_di_q  <= g1_di_q;
    g2_pm_q  <= g1_pm_q;
    g2_p3_q  <= MAG_W'(p3_prod[DI_W+23:FRAC_BITS]);
    g2_p4_q  <= p4_prod[DI_W+31:FRAC_BITS];
  end

  // output register
  rsp_t rsp_d;
  logic grads_on;
  assign grads_on = g2_ctx_q.ramp && g2_ctx_q.want;

  always_comb begin
    rsp_d.damage_factor   = g2_ctx_q.damage;
    rsp_d.span_degenerate = g2_ctx_q.degen;
    rsp_d.grad_intensity  = grads_on ? GRAD_W'(g2_di_q) : '0;
    rsp_d.grad_min_bound  = grads_on ? neg_sat(MAG_W'(g2_pm_q)) : '0;
    rsp_d.grad_max_bound  = grads_on ? neg_sat(g2_p3_q) : '0;
    rsp_d.grad_scale      = grads_on ? neg_sat(g2_p4_q) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= g2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    result_o <= rsp_d;
  end

endmodule
`default_nettype wire

// File: hw/rtl/rcr_checker.sv
// Port-level checks of the raised-cosine ramp core, bound to its top level.
`default_nettype none
module rcr_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start_i,
  input wire rcr_pkg::req_t req_i,
  input wire logic          busy_o,
  input wire logic          done_o,
  input wire rcr_pkg::rsp_t result_o
);
  import rcr_pkg::*;

  logic grads_zero;
  assign grads_zero = (result_o.grad_intensity == '0) && (result_o.grad_min_bound == '0)
                   && (result_o.grad_max_bound == '0) && (result_o.grad_scale == '0);

  a_done_follows_txn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result without a transaction at the pipeline depth");

  a_damage_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.damage_factor <= DF_ONE))
    else $error("damage above one");

  a_degen_no_grads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.span_degenerate) |-> grads_zero)
    else $error("gradients on a degenerate span");

  a_no_request_no_grads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !$past(req_i.want_gradients, LATENCY)) |-> grads_zero)
    else $error("gradients given without request");

  a_grad_signs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!result_o.grad_intensity[GRAD_W-1]
                && (result_o.grad_min_bound <= 0)))
    else $error("gradient sign wrong");

endmodule

bind raised_cosine_ramp_with_gradients_core rcr_checker u_rcr_checker (.*);
`default_nettype wire
